FILE: rtl/stpars_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// stpars_pkg: shared types and constants of the segment tree block
// Item and result payloads, controller states, datapath operations and the
// status returned from the datapath to the controller.
// ============================================================================
package stpars_pkg;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned END_W   = 11;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LCOUNT_W = 11;

    localparam logic [LCOUNT_W-1:0] LEAF_COUNT_RESET = 11'd1024;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [POS_W-1:0]         position;
        logic [END_W-1:0]         end_position;
        logic signed [DATA_W-1:0] delta;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_sum;
        logic                     bad_range;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_LEAF,
        ST_ADD_UP,
        ST_Q_LO,
        ST_Q_HI,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD_ADD,
        DP_LOAD_QUERY,
        DP_ADD_RD,
        DP_ADD_LEAF,
        DP_ADD_UP,
        DP_Q_LO,
        DP_Q_HI,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        logic is_query;
        logic add_ok;
        logic q_bad;
        logic q_empty;
        logic clear_last;
        logic node_root;
        logic parent_root;
        logic lo_lt_hi;
        logic result_free;
    } status_t;

endpackage

FILE: rtl/stpars_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// stpars_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module stpars_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/stpars_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// stpars_dp: datapath of the segment tree block
// Holds the tree store, the leaf count, the walk registers, the accumulator
// and the result register, and carries out one operation per cycle.
// ============================================================================
module stpars_dp #(
    parameter int unsigned MAX_LEAVES = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stpars_pkg::dp_op_t                     op,
    output stpars_pkg::status_t                    status,
    input  stpars_pkg::item_t                      item,
    input  logic                                   cfg_valid,
    input  logic [stpars_pkg::LCOUNT_W-1:0]        cfg_leaf_count,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output stpars_pkg::result_t                    result
);

    localparam int unsigned NODES = 2 * MAX_LEAVES;
    localparam int unsigned AW    = $clog2(NODES);
    localparam int unsigned LW    = AW + 1;
    localparam int unsigned DW    = stpars_pkg::DATA_W;

    logic [stpars_pkg::LCOUNT_W-1:0] leaf_count_reg;
    logic [AW-1:0]                   node_reg, node_next;
    logic [LW-1:0]                   lo_reg, lo_next;
    logic [LW-1:0]                   hi_reg, hi_next;
    logic [DW-1:0]                   acc_reg, acc_next;
    logic                            pend_reg, pend_next;
    logic                            bad_reg, bad_next;
    stpars_pkg::result_t             result_reg, result_next;
    logic                            result_valid_reg, result_valid_next;

    logic [AW-1:0] leaves;
    logic [LW-1:0] lo_init;
    logic [LW-1:0] hi_init;
    logic [AW-1:0] parent;
    logic [DW-1:0] sum;
    logic [DW-1:0] acc_pend;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    stpars_ram #(
        .WIDTH (DW),
        .DEPTH (NODES)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (leaf_count_reg == '0)
        begin
            leaves = AW'(1);
        end
        else if (32'(leaf_count_reg) > 32'(MAX_LEAVES))
        begin
            leaves = AW'(MAX_LEAVES);
        end
        else
        begin
            leaves = AW'(leaf_count_reg);
        end
    end

    assign lo_init  = LW'(leaves) + LW'(item.position);
    assign hi_init  = LW'(leaves) + LW'(item.end_position);
    assign parent   = node_reg >> 1;
    assign acc_pend = acc_reg + (pend_reg ? ram_rdata : '0);

    always_comb
    begin
        status.is_query    = (item.func == stpars_pkg::FUNC_QUERY);
        status.add_ok      = 32'(item.position) < 32'(leaves);
        status.q_bad       = 32'(item.end_position) > 32'(leaves);
        status.q_empty     = 32'(item.position) >= 32'(item.end_position);
        status.clear_last  = (node_reg == AW'(NODES - 1));
        status.node_root   = (node_reg == AW'(1));
        status.parent_root = (parent == AW'(1));
        status.lo_lt_hi    = (lo_reg < hi_reg);
        status.result_free = !result_valid_reg || result_ready;
    end

    always_comb
    begin
        node_next         = node_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        acc_next          = acc_reg;
        pend_next         = 1'b0;
        bad_next          = bad_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        ram_we            = 1'b0;
        ram_waddr         = node_reg;
        ram_wdata         = acc_reg;
        ram_raddr         = node_reg;
        sum               = acc_reg + ram_rdata;
        unique case (op)
            stpars_pkg::DP_NOP:
            begin
            end
            stpars_pkg::DP_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                node_next = node_reg + AW'(1);
            end
            stpars_pkg::DP_LOAD_ADD:
            begin
                node_next = AW'(lo_init);
                acc_next  = DW'(item.delta);
            end
            stpars_pkg::DP_LOAD_QUERY:
            begin
                lo_next  = lo_init;
                hi_next  = hi_init;
                acc_next = '0;
                bad_next = status.q_bad;
            end
            stpars_pkg::DP_ADD_RD:
            begin
                ram_raddr = node_reg;
            end
            stpars_pkg::DP_ADD_LEAF:
            begin
                ram_we    = 1'b1;
                ram_wdata = sum;
                acc_next  = sum;
                ram_raddr = node_reg ^ AW'(1);
            end
            stpars_pkg::DP_ADD_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = sum;
                acc_next  = sum;
                node_next = parent;
                ram_raddr = parent ^ AW'(1);
            end
            stpars_pkg::DP_Q_LO:
            begin
                acc_next = acc_pend;
                if (lo_reg[0] && status.lo_lt_hi)
                begin
                    ram_raddr = lo_reg[AW-1:0];
                    pend_next = 1'b1;
                    lo_next   = lo_reg + LW'(1);
                end
            end
            stpars_pkg::DP_Q_HI:
            begin
                acc_next = acc_pend;
                if (hi_reg[0])
                begin
                    ram_raddr = AW'(hi_reg - LW'(1));
                    pend_next = 1'b1;
                end
                hi_next = (hi_reg - LW'(hi_reg[0])) >> 1;
                lo_next = lo_reg >> 1;
            end
            stpars_pkg::DP_OUT:
            begin
                result_next.range_sum = acc_reg;
                result_next.bad_range = bad_reg;
                result_valid_next     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg   <= stpars_pkg::LEAF_COUNT_RESET;
            node_reg         <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                leaf_count_reg <= cfg_leaf_count;
            end
            node_reg         <= node_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        acc_reg    <= acc_next;
        bad_reg    <= bad_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/stpars_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// stpars_ctrl: controller of the segment tree block
// Sequences the clearing pass, the leaf-to-root update of an add and the
// two-sided walk of a range query, one datapath operation per cycle.
// ============================================================================
module stpars_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  stpars_pkg::status_t status,
    output stpars_pkg::dp_op_t  op
);

    stpars_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stpars_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = stpars_pkg::DP_NOP;
        item_ready = 1'b0;
        unique case (state_reg)
            stpars_pkg::ST_CLEAR:
            begin
                op = stpars_pkg::DP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = stpars_pkg::ST_IDLE;
                end
            end
            stpars_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (status.is_query)
                    begin
                        op = stpars_pkg::DP_LOAD_QUERY;
                        if (status.q_bad || status.q_empty)
                        begin
                            state_next = stpars_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = stpars_pkg::ST_Q_LO;
                        end
                    end
                    else if (status.add_ok)
                    begin
                        op         = stpars_pkg::DP_LOAD_ADD;
                        state_next = stpars_pkg::ST_ADD_RD;
                    end
                end
            end
            stpars_pkg::ST_ADD_RD:
            begin
                op         = stpars_pkg::DP_ADD_RD;
                state_next = stpars_pkg::ST_ADD_LEAF;
            end
            stpars_pkg::ST_ADD_LEAF:
            begin
                op = stpars_pkg::DP_ADD_LEAF;
                if (status.node_root)
                begin
                    state_next = stpars_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = stpars_pkg::ST_ADD_UP;
                end
            end
            stpars_pkg::ST_ADD_UP:
            begin
                op = stpars_pkg::DP_ADD_UP;
                if (status.parent_root)
                begin
                    state_next = stpars_pkg::ST_IDLE;
                end
            end
            stpars_pkg::ST_Q_LO:
            begin
                op = stpars_pkg::DP_Q_LO;
                if (status.lo_lt_hi)
                begin
                    state_next = stpars_pkg::ST_Q_HI;
                end
                else
                begin
                    state_next = stpars_pkg::ST_OUT;
                end
            end
            stpars_pkg::ST_Q_HI:
            begin
                op         = stpars_pkg::DP_Q_HI;
                state_next = stpars_pkg::ST_Q_LO;
            end
            stpars_pkg::ST_OUT:
            begin
                if (status.result_free)
                begin
                    op         = stpars_pkg::DP_OUT;
                    state_next = stpars_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stpars_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/segment_tree_point_add_range_sum.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_tree_point_add_range_sum: point-add / range-sum segment tree
// Bottom-up segment tree of 32-bit wrapping sums over up to MAX_LEAVES leaves.
//
// Items arrive on the item channel as beats of func, position, end_position
// and delta. An add beat updates one leaf and every ancestor and returns
// nothing; a query beat returns one result beat of range_sum and bad_range.
// The cfg channel writes the leaf count and is always ready.
// One item is worked on at a time; the tree store is a single RAM with one
// read and one write port, and the number of tree levels sets the latency.
// An add reads its leaf, writes it and then each ancestor up to the root,
// and an add at a position at or above the leaf count is dropped. A query
// walks both ends of the range up the tree; an out-of-range or empty query
// goes straight to the output state. After reset the block clears all
// 2 * MAX_LEAVES tree nodes, one node per cycle, with item_ready low; the
// leaf count resets to 1024. A result beat waits in an output register while
// result_ready is low; the next item is still taken, and a further query
// holds there until the register is free.
// ============================================================================
module segment_tree_point_add_range_sum #(
    parameter int unsigned MAX_LEAVES = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  stpars_pkg::item_t               item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output stpars_pkg::result_t             result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stpars_pkg::LCOUNT_W-1:0] cfg_leaf_count
);

    stpars_pkg::dp_op_t  op;
    stpars_pkg::status_t status;

    assign cfg_ready = 1'b1;

    stpars_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .op         (op)
    );

    stpars_dp #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .status         (status),
        .item           (item),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_leaf_count (cfg_leaf_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result)
    );

    // A flagged range always carries a zero sum.
    a_bad_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_range |-> result.range_sum == '0)
    else $error("bad range result with non-zero sum");

    // A new result only appears after the datapath has loaded one.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(op) == stpars_pkg::DP_OUT)
    else $error("result valid without a result load");

    // No item is taken while the tree store is still being cleared.
    a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        op == stpars_pkg::DP_CLEAR |-> !item_ready)
    else $error("item ready during clearing pass");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        op == stpars_pkg::DP_OUT |-> !result_valid || result_ready)
    else $error("result overwritten while stalled");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the point-add / range-sum segment tree
// A shadow tree predicts every query result as each item beat is accepted,
// and a small scoreboard compares the result beats in order. A short directed
// sequence is followed by random phases over several leaf counts, with random
// idling on both channels, a long result stall and a full drain mid-phase.
// ============================================================================
module tb_top;

    localparam int unsigned TREE_LEAVES     = 1024;
    localparam int unsigned IDLE_PCT        = 32;
    localparam int unsigned PHASES          = 11;
    localparam int unsigned ITEMS_PER_PHASE = 115;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned WATCHDOG_LIMIT  = 20000;

    class tree_sum_checker;
        logic [stpars_pkg::DATA_W-1:0]   node_sum [2*TREE_LEAVES];
        logic [stpars_pkg::LCOUNT_W-1:0] leaf_reg;
        stpars_pkg::result_t             sums_due [$];
        int unsigned                     errors, adds, ignored_adds, queries;
        int unsigned                     flagged, empties, checked, cfg_writes;

        function new();
            foreach (node_sum[i])
                node_sum[i] = '0;
            leaf_reg = stpars_pkg::LEAF_COUNT_RESET;
        endfunction

        function void set_leaf_count(logic [stpars_pkg::LCOUNT_W-1:0] value);
            leaf_reg = value;
            cfg_writes++;
        endfunction

        function int unsigned leaves();
            if (leaf_reg == '0)
                return 1;
            if (32'(leaf_reg) > TREE_LEAVES)
                return TREE_LEAVES;
            return 32'(leaf_reg);
        endfunction

        function int unsigned pending();
            return sums_due.size();
        endfunction

        function void take_item(stpars_pkg::item_t it);
            int unsigned                   n, node, lo, hi;
            logic [stpars_pkg::DATA_W-1:0] left_acc, right_acc;
            stpars_pkg::result_t           due;
            n = leaves();
            if (it.func == stpars_pkg::FUNC_ADD)
            begin
                adds++;
                if (32'(it.position) >= n)
                begin
                    ignored_adds++;
                    return;
                end
                node = n + 32'(it.position);
                node_sum[node] = node_sum[node] + it.delta;
                for (node = node >> 1; node > 0; node = node >> 1)
                    node_sum[node] = node_sum[2*node] + node_sum[2*node+1];
                return;
            end
            queries++;
            due.range_sum = '0;
            due.bad_range = 1'b0;
            if (32'(it.end_position) > n)
            begin
                due.bad_range = 1'b1;
                flagged++;
            end
            else if (32'(it.position) >= 32'(it.end_position))
            begin
                empties++;
            end
            else
            begin
                left_acc  = '0;
                right_acc = '0;
                lo = n + 32'(it.position);
                hi = n + 32'(it.end_position);
                while (lo < hi)
                begin
                    if (lo[0])
                    begin
                        left_acc = left_acc + node_sum[lo];
                        lo++;
                    end
                    if (hi[0])
                    begin
                        hi--;
                        right_acc = right_acc + node_sum[hi];
                    end
                    lo = lo >> 1;
                    hi = hi >> 1;
                end
                due.range_sum = left_acc + right_acc;
            end
            sums_due.push_back(due);
        endfunction

        function void check_sum(stpars_pkg::result_t got);
            stpars_pkg::result_t due;
            if (sums_due.size() == 0)
            begin
                $error("result beat arrived with no query outstanding");
                errors++;
                return;
            end
            due = sums_due.pop_front();
            checked++;
            if (got.range_sum !== due.range_sum)
            begin
                $error("range_sum mismatch: expected %0d, actual %0d",
                       due.range_sum, got.range_sum);
                errors++;
            end
            if (got.bad_range !== due.bad_range)
            begin
                $error("bad_range mismatch: expected %0b, actual %0b",
                       due.bad_range, got.bad_range);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            item_valid;
    logic                            item_ready;
    stpars_pkg::item_t               item_data;
    logic                            result_valid;
    logic                            result_ready;
    stpars_pkg::result_t             result_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [stpars_pkg::LCOUNT_W-1:0] cfg_leaf_count;

    tree_sum_checker                 sb;
    int unsigned                     tx_idle_pct;
    int unsigned                     rx_idle_pct;
    bit                              hold_req;
    logic [stpars_pkg::LCOUNT_W-1:0] leaf_plan [PHASES-1];

    segment_tree_point_add_range_sum #(
        .MAX_LEAVES(TREE_LEAVES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item_data),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_leaf_count(cfg_leaf_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_leaf_count(cfg_leaf_count);
            if (item_valid && item_ready)
                sb.take_item(item_data);
            if (result_valid && result_ready)
                sb.check_sum(result_data);
        end
    end

    initial
    begin : result_sink
        int unsigned stall;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    // Called just after a rising edge; leaves valid high on return.
    task automatic send_item(input stpars_pkg::item_t it);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic issue_add(input int unsigned pos,
                             input logic [stpars_pkg::DATA_W-1:0] amount);
        stpars_pkg::item_t it;
        it.func         = stpars_pkg::FUNC_ADD;
        it.position     = stpars_pkg::POS_W'(pos);
        it.end_position = '0;
        it.delta        = amount;
        send_item(it);
    endtask

    task automatic issue_query(input int unsigned lo, input int unsigned hi);
        stpars_pkg::item_t it;
        it.func         = stpars_pkg::FUNC_QUERY;
        it.position     = stpars_pkg::POS_W'(lo);
        it.end_position = stpars_pkg::END_W'(hi);
        it.delta        = $urandom;
        send_item(it);
    endtask

    task automatic settle_tree();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_leaf_count(input logic [stpars_pkg::LCOUNT_W-1:0] value);
        @(negedge clk);
        cfg_valid      <= 1'b1;
        cfg_leaf_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stpars_pkg::item_t random_item(input int unsigned n);
        stpars_pkg::item_t it;
        int unsigned       pick;
        pick = $urandom_range(99);
        it.func = ($urandom_range(1) == 1) ? stpars_pkg::FUNC_QUERY : stpars_pkg::FUNC_ADD;
        case ($urandom_range(9))
            0:       it.delta = 32'h7FFF_FFFF;
            1:       it.delta = 32'h8000_0000;
            2, 3, 4: it.delta = 32'($urandom_range(200)) - 32'd100;
            default: it.delta = $urandom;
        endcase
        it.position     = stpars_pkg::POS_W'($urandom_range(n - 1));
        it.end_position = stpars_pkg::END_W'($urandom_range(n, 32'(it.position) + 1));
        if (pick < 6)
        begin
            it.position     = stpars_pkg::POS_W'($urandom_range(TREE_LEAVES - 1));
            it.end_position = stpars_pkg::END_W'($urandom_range(TREE_LEAVES));
        end
        else if (pick < 12)
            it.end_position = stpars_pkg::END_W'(it.position);
        else if (pick < 18)
            it.end_position = stpars_pkg::END_W'($urandom_range(TREE_LEAVES, n));
        return it;
    endfunction

    initial
    begin : stimulus
        int unsigned                     phase, k;
        logic [stpars_pkg::LCOUNT_W-1:0] setting;
        sb = new();
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item_data      = '0;
        cfg_valid      = 1'b0;
        cfg_leaf_count = '0;
        tx_idle_pct    = IDLE_PCT;
        rx_idle_pct    = IDLE_PCT;
        hold_req       = 1'b0;
        leaf_plan = '{11'd1024, 11'd1, 11'd2, 11'd3, 11'd0,
                      11'd17, 11'd512, 11'd1023, 11'd2047, 11'd1025};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes at the reset leaf count; the full-range total wraps.
        issue_add(0, 32'h7FFF_FFFF);
        issue_add(1023, 32'h8000_0000);
        issue_add(511, 32'hFFFF_FFFF);
        issue_add(512, 32'h0000_0001);
        issue_query(0, 1024);
        issue_query(0, 1);
        issue_query(1023, 1024);
        issue_query(511, 513);
        issue_query(300, 300);
        issue_query(1000, 3);
        issue_query(1, 1023);
        settle_tree();

        // A zero leaf count behaves as one leaf.
        write_leaf_count(11'd0);
        issue_add(0, 32'd5);
        issue_add(1, 32'd9);
        issue_add(1023, 32'd7);
        issue_query(0, 1);
        issue_query(0, 2);
        issue_query(1, 1);
        issue_query(5, 3);
        issue_query(0, 1024);
        settle_tree();

        // An oversized count clamps, and the old words are read in the new layout.
        write_leaf_count(11'd2047);
        issue_query(0, 1024);
        issue_query(1, 2);

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle_tree();
            setting = (phase < PHASES - 1) ? leaf_plan[phase] :
                      stpars_pkg::LCOUNT_W'($urandom_range(TREE_LEAVES, 1));
            write_leaf_count(setting);
            tx_idle_pct = (phase == 8) ? 0 : IDLE_PCT;
            rx_idle_pct = tx_idle_pct;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (phase == 0 && k == 20)
                    hold_req = 1'b1;
                if (phase == 6 && k == ITEMS_PER_PHASE / 2)
                    settle_tree();
                send_item(random_item(sb.leaves()));
            end
        end
        settle_tree();

        $display("Covered %0d items: %0d adds (%0d out of range), %0d queries %s",
                 sb.adds + sb.queries, sb.adds, sb.ignored_adds, sb.queries,
                 $sformatf("(%0d flagged, %0d empty).", sb.flagged, sb.empties));
        $display("Leaf count written %0d times; %0d sums checked with %0d mismatches.",
                 sb.cfg_writes, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
